// ----- rtl/core/lpms_pkg.sv -----
`default_nettype none
package lpms_pkg;
  localparam int MapSide  = 256;
  localparam int MapAw    = 16;
  localparam int MaxBeams = 1024;
  localparam int CntW     = 11;

  localparam logic [21:0] Deg360 = 22'd1474560;
  localparam logic [21:0] Deg180 = 22'd737280;
  localparam logic [21:0] Deg90  = 22'd368640;
  localparam logic [19:0] CordicStart = 20'd39797;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_POSE  = 2'd1,
    OP_BEAM  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_MAX_RANGE = 2'd0,
    REG_MARGIN    = 2'd1,
    REG_STEP      = 2'd2,
    REG_CPM       = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANG, ST_MOD, ST_FOLD, ST_CORDIC, ST_RMUL, ST_PX, ST_PY,
    ST_SUM, ST_RD, ST_CNT, ST_DIV, ST_OUT
  } state_e;

  function automatic logic [21:0] atan_lut(input logic [3:0] i);
    logic [21:0] v;
    case (i)
      4'd0: v = 22'd184320;  4'd1: v = 22'd108810; 4'd2: v = 22'd57492;
      4'd3: v = 22'd29184;   4'd4: v = 22'd14649;  4'd5: v = 22'd7331;
      4'd6: v = 22'd3667;    4'd7: v = 22'd1833;   4'd8: v = 22'd917;
      4'd9: v = 22'd458;     4'd10: v = 22'd229;   4'd11: v = 22'd115;
      4'd12: v = 22'd57;     4'd13: v = 22'd29;    4'd14: v = 22'd14;
      default: v = 22'd7;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/lpms_map_ram.sv -----
`default_nettype none
module lpms_map_ram (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [lpms_pkg::MapAw-1:0] waddr_i,
  input  wire logic                     wdata_i,
  input  wire logic [lpms_pkg::MapAw-1:0] raddr_i,
  output logic                          rdata_o
);
  import lpms_pkg::*;
  logic mem [MapSide*MapSide];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/core/lidar_particle_map_score.sv -----
`default_nettype none
// Beam endpoint scorer. A map cell write (op 0) and a pose (op 1, which also
// clears the counters) are taken without holding off the input, and so is a
// beam that is out of range or over the beam cap and not the last one. A beam
// in range and under the cap holds off the input while it forms the angle and
// does the 360 degree reduction: a reciprocal estimate of the turn count,
// then at most one final compare and subtract. These are followed by a fold
// step, a 16-step iterative CORDIC, three registered multiplies, the endpoint
// sum, a registered map memory read and the count update. On the last beam of
// a scan, a 17-step restoring divide and an output state follow, and the
// score becomes valid as the output state ends. A last beam that is not
// counted goes straight to the divide. The score is held in an output
// register until it is taken, and the input stalls while a score is waiting.
module lidar_particle_map_score (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  map_x_i,
  input  wire logic [7:0]  map_y_i,
  input  wire logic        cell_occupied_i,
  input  wire logic signed [15:0] pose_x_i,
  input  wire logic signed [15:0] pose_y_i,
  input  wire logic signed [13:0] pose_heading_i,
  input  wire logic [9:0]  beam_index_i,
  input  wire logic [15:0] beam_distance_i,
  input  wire logic        last_beam_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [16:0]      belief_o,
  output logic [10:0]      hit_count_o,
  output logic [10:0]      miss_count_o,
  output logic             no_valid_beams_o
);
  import lpms_pkg::*;

  logic [15:0] max_range_q, step_q, cpm_q;
  logic [7:0]  margin_q;
  logic signed [15:0] cx_q, cy_q;
  logic signed [13:0] ch_q;
  logic [CntW-1:0] hits_q, miss_q;
  state_e st_q, st_d;
  logic [9:0]  idx_q;
  logic [15:0] dist_q;
  logic        last_q, valid_q, neg_q;
  logic signed [27:0] ang_q;
  logic signed [22:0] z_q;
  logic signed [19:0] x_q, y_q;
  logic [4:0]  it_q;
  logic [31:0] r_q;
  logic signed [52:0] px_q, py_q;
  logic signed [52:0] ex_q, ey_q;
  logic        onmap_q;
  logic [16:0] quo_q;
  logic [27:0] rem_q;
  logic        ovf_q;

  logic accept, busy_out;
  assign busy_out = out_valid_o & out_stall_i;
  assign in_stall_o = (st_q != ST_IDLE) | busy_out;
  assign accept = in_valid_i & ~in_stall_o;

  logic map_we, map_rd;
  logic [MapAw-1:0] raddr;
  assign map_we = accept && (op_i == OP_WRITE);
  assign raddr = {ey_q[7:0], ex_q[7:0]};
  lpms_map_ram u_ram (.clk_i, .we_i(map_we), .waddr_i({map_y_i, map_x_i}),
    .wdata_i(cell_occupied_i), .raddr_i(raddr), .rdata_o(map_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_range_q <= 16'd16384; margin_q <= 8'd4;
      step_q <= 16'd4096; cpm_q <= 16'd5120;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAX_RANGE: max_range_q <= cfg_data_i;
        REG_MARGIN:    margin_q <= cfg_data_i[7:0];
        REG_STEP:      step_q <= cfg_data_i;
        default:       cpm_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else st_q <= st_d;
  end

  // Beams are valid when in range and the scan has not hit its beam cap.
  logic beam_ok;
  assign beam_ok = ({1'b0, beam_distance_i} + {9'd0, margin_q} < {1'b0, max_range_q})
                   && ({1'b0, hits_q} + {1'b0, miss_q} < 12'(MaxBeams));

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (accept && op_i == OP_BEAM) st_d = beam_ok ? ST_ANG :
                   (last_beam_i ? ST_DIV : ST_IDLE);
      ST_ANG:    st_d = ST_MOD;
      ST_MOD:    if (ang_q < $signed({6'd0, Deg360}) && ang_q >= 0) st_d = ST_FOLD;
      ST_FOLD:   st_d = ST_CORDIC;
      ST_CORDIC: if (it_q == 5'd15) st_d = ST_RMUL;
      ST_RMUL:   st_d = ST_PX;
      ST_PX:     st_d = ST_PY;
      ST_PY:     st_d = ST_SUM;
      ST_SUM:    st_d = ST_RD;
      ST_RD:     st_d = ST_CNT;
      ST_CNT:    st_d = last_q ? ST_DIV : ST_IDLE;
      ST_DIV:    if (it_q == 5'd16) st_d = ST_OUT;
      ST_OUT:    st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // A full turn is 45 * 2^15. The turn count is estimated from the angle's
  // upper bits with a reciprocal of 45 that never overshoots, so after one
  // subtraction at most one more full turn remains.
  logic [11:0] mod_u;
  logic [21:0] mod_p;
  logic [5:0]  mod_q;
  logic [27:0] mod_sub;
  assign mod_u = ang_q[26:15];
  assign mod_p = mod_u * 11'd1456;
  assign mod_q = mod_p[21:16];
  assign mod_sub = (mod_q == 6'd0) ? 28'(Deg360) :
                   {1'b0, 12'(mod_q) * 12'd45, 15'd0};

  logic signed [19:0] ysh, xsh;
  assign ysh = y_q >>> it_q[3:0];
  assign xsh = x_q >>> it_q[3:0];
  logic [11:0] tot;
  assign tot = {1'b0, hits_q} + {1'b0, miss_q};
  logic [28:0] trial;
  assign trial = {rem_q, quo_q[16]} - {17'd0, tot};
  logic [CntW-1:0] hits_new;
  assign hits_new = (onmap_q && map_rd) ? hits_q + 1'b1 : hits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; ch_q <= '0; hits_q <= '0; miss_q <= '0;
      valid_q <= 1'b0; it_q <= '0;
    end else begin
      if (out_valid_o && !out_stall_i) valid_q <= 1'b0;
      case (st_q)
        ST_IDLE: if (accept) begin
          idx_q <= beam_index_i; dist_q <= beam_distance_i; last_q <= last_beam_i;
          it_q <= '0;
          if (op_i == OP_POSE) begin
            cx_q <= pose_x_i; cy_q <= pose_y_i; ch_q <= pose_heading_i;
            hits_q <= '0; miss_q <= '0;
          end else if (op_i == OP_BEAM && !beam_ok && last_beam_i) begin
            // The dividend is hits * 2^16; its bits above bit 16 start as
            // the partial remainder.
            quo_q <= {hits_q[0], 16'd0}; rem_q <= 28'(hits_q >> 1);
          end
        end
        ST_ANG: ang_q <= 28'(ch_q * 256) + 28'(Deg180) +
                         $signed({2'b0, 26'(idx_q) * step_q});
        ST_MOD: if (ang_q < 0) ang_q <= ang_q + 28'(Deg360);
                else if (ang_q >= $signed({6'd0, Deg360})) ang_q <= ang_q - mod_sub;
        ST_FOLD: begin
          x_q <= 20'(CordicStart); y_q <= '0; it_q <= '0;
          if (ang_q > $signed({6'd0, Deg180})) begin
            if (ang_q - 28'(Deg360) < -$signed({6'd0, Deg90})) begin
              z_q <= 23'(ang_q - 28'(Deg180)); neg_q <= 1'b1;
            end else begin z_q <= 23'(ang_q - 28'(Deg360)); neg_q <= 1'b0; end
          end else if (ang_q > $signed({6'd0, Deg90})) begin
            z_q <= 23'(ang_q - 28'(Deg180)); neg_q <= 1'b1;
          end else begin z_q <= 23'(ang_q); neg_q <= 1'b0; end
        end
        ST_CORDIC: begin
          it_q <= it_q + 5'd1;
          if (z_q >= 0) begin
            x_q <= x_q - ysh; y_q <= y_q + xsh; z_q <= z_q - $signed({1'b0, atan_lut(it_q[3:0])});
          end else begin
            x_q <= x_q + ysh; y_q <= y_q - xsh; z_q <= z_q + $signed({1'b0, atan_lut(it_q[3:0])});
          end
        end
        ST_RMUL: begin
          r_q <= dist_q * cpm_q;
          if (neg_q) begin x_q <= -x_q; y_q <= -y_q; end
        end
        ST_PX: px_q <= 53'($signed({1'b0, r_q}) * x_q);
        ST_PY: py_q <= 53'($signed({1'b0, r_q}) * y_q);
        ST_SUM: begin
          // Truncating divide by 2^36: bias negative sums before the shift.
          ex_q <= ((53'(cx_q) <<< 32) + px_q + (((53'(cx_q) <<< 32) + px_q) < 0 ?
                   53'(36'hF_FFFF_FFFF) : 53'd0)) >>> 36;
          ey_q <= ((53'(cy_q) <<< 32) + py_q + (((53'(cy_q) <<< 32) + py_q) < 0 ?
                   53'(36'hF_FFFF_FFFF) : 53'd0)) >>> 36;
        end
        ST_RD: onmap_q <= (ex_q >= 0) && (ex_q < MapSide) && (ey_q >= 0) && (ey_q < MapSide);
        ST_CNT: begin
          if (onmap_q && map_rd) hits_q <= hits_q + 1'b1;
          else miss_q <= miss_q + 1'b1;
          it_q <= '0;
          quo_q <= {hits_new[0], 16'd0};
          rem_q <= 28'(hits_new >> 1);
        end
        ST_DIV: begin
          it_q <= it_q + 5'd1;
          if (!trial[28]) begin
            rem_q <= trial[27:0]; quo_q <= {quo_q[15:0], 1'b1};
          end else begin
            rem_q <= {rem_q[26:0], quo_q[16]}; quo_q <= {quo_q[15:0], 1'b0};
          end
        end
        ST_OUT: begin
          valid_q <= 1'b1;
          belief_o <= (tot == 0) ? 17'd0 : quo_q;
          hit_count_o <= hits_q; miss_count_o <= miss_q;
          no_valid_beams_o <= (tot == 0);
          hits_q <= '0; miss_q <= '0;
        end
        default: ;
      endcase
    end
  end
  assign out_valid_o = valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> in_stall_o) else $error("accept while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_OUT) |=> out_valid_o) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_valid_beams_o) |-> (belief_o == 17'd0)) else $error("empty belief");
endmodule
`default_nettype wire
